### rtl/shadowed_oled_pixel_writer_unit_macros.svh
// Assertion helpers for the pixel writer back end.
// Each expects clk and rst_n in scope.
`ifndef SHADOWED_OLED_PIXEL_WRITER_UNIT_MACROS_SVH
`define SHADOWED_OLED_PIXEL_WRITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SOPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOPW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sopw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sopw_pkg;

  // Byte index width: page (4 bits) times up to 256 columns plus x.
  localparam int IDX_W = 12;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Panel controller command codes.
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  typedef enum logic [1:0] {
    STAT_UNCHANGED = 2'd0,
    STAT_SENT      = 2'd1,
    STAT_OFFSCREEN = 2'd2
  } sopw_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } sopw_state_t;

  // One classified pixel write.
  typedef struct packed {
    logic             offscreen;
    logic [IDX_W-1:0] index;
    logic [2:0]       bit_sel;
    logic             color;
    logic [3:0]       page;
    logic [7:0]       x;
  } sopw_item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } sopw_result_t;

endpackage

`default_nettype wire

### rtl/sopw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sopw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x;
  logic [6:0] y;
  logic       color;

  modport source (output valid, x, y, color, input ready);
  modport sink   (input valid, x, y, color, output ready);
endinterface

`default_nettype wire

### rtl/sopw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sopw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       has_byte;
  logic       last;
  logic [1:0] status;

  modport source (output valid, out_byte, is_data, has_byte, last, status, input ready);
  modport sink   (input valid, out_byte, is_data, has_byte, last, status, output ready);
endinterface

`default_nettype wire

### rtl/shadowed_oled_pixel_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel writer for a 128x64 monochrome page-mode panel with a shadow frame
// store. Each accepted word (x, y, color) sets or clears one bit of byte
// (y >> 3) * ROW_BYTES + x; an index past FRAME_BYTES - 1 gives one
// off-screen status word, an unchanged byte gives one unchanged status word,
// and a changed byte gives four words: page command, low-column command,
// high-column command and the data byte, the last one flagged. After reset
// the store is cleared one byte per cycle, so no input is taken until the
// clear pass ends. A front end classifies input into a two-entry queue; the
// back end does the store read-modify-write and emits at most one result
// word per cycle, held while the receiver is not ready. An off-screen pixel
// goes from idle straight to the emit state; any other pixel first passes a
// look state for the registered read of the shadow store.
module shadowed_oled_pixel_writer_unit
  import sopw_pkg::*;
#(
  parameter int FRAME_BYTES = 1024,
  parameter int ROW_BYTES   = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sopw_in_if.sink    in_if,
  sopw_out_if.source out_if
);

  logic       push;
  sopw_item_t push_item;
  logic       pop;
  sopw_item_t head_item;
  logic       head_valid;
  logic       q_full;
  logic       clr_busy;

  // Accept and classify.
  sopw_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .ROW_BYTES   (ROW_BYTES)
  ) u_front (
    .in_if     (in_if),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple front from back.
  sopw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_item  (head_item),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // Update the shadow store and emit words.
  sopw_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .head_valid (head_valid),
    .pop        (pop),
    .clr_busy   (clr_busy),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

### rtl/sopw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sopw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/sopw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sopw_queue
  import sopw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire sopw_item_t push_item,
  input  wire logic       pop,
  output sopw_item_t      head_item,
  output logic            head_valid,
  output logic            full
);

  sopw_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_item  = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == QCNT_W'(QDEPTH));

  // Store pushed items.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sopw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sopw_front
  import sopw_pkg::*;
#(
  parameter int FRAME_BYTES = 1024,
  parameter int ROW_BYTES   = 128
) (
  sopw_in_if.sink   in_if,
  input  wire logic clr_busy,
  input  wire logic q_full,
  output logic      push,
  output sopw_item_t push_item
);

  logic [3:0]       page;
  logic [IDX_W-1:0] index;

  // Hold off input while the store clears or the queue is full.
  assign in_if.ready = !q_full && !clr_busy;
  assign push        = in_if.valid && in_if.ready;

  // Classify: byte index, bit, off-screen check.
  assign page  = in_if.y[6:3];
  assign index = IDX_W'(page) * IDX_W'(ROW_BYTES) + IDX_W'(in_if.x);

  always_comb begin
    push_item.offscreen = (index > IDX_W'(FRAME_BYTES - 1));
    push_item.index     = index;
    push_item.bit_sel   = in_if.y[2:0];
    push_item.color     = in_if.color;
    push_item.page      = page;
    push_item.x         = in_if.x;
  end

endmodule

`default_nettype wire

### rtl/sopw_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shadowed_oled_pixel_writer_unit_macros.svh"

module sopw_back
  import sopw_pkg::*;
#(
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sopw_item_t head_item,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            clr_busy,
  sopw_out_if.source      out_if
);

  localparam int AW = $clog2(FRAME_BYTES);

  sopw_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]    emit_cnt_r, emit_cnt_nxt;
  sopw_status_t  kind_r, kind_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic          color_r, color_nxt;
  logic [3:0]    page_r, page_nxt;
  logic [7:0]    x_r, x_nxt;
  logic [7:0]    after_r, after_nxt;
  logic          out_valid_r, out_valid_nxt;
  sopw_result_t  out_r, out_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    mask;
  logic [7:0]    new_byte;
  logic          load;

  // Shadow frame store.
  sopw_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_item.index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Read-modify of the addressed byte.
  assign mask     = 8'(1) << bit_r;
  assign new_byte = color_r ? (ram_rdata | mask) : (ram_rdata & ~mask);

  // In the emit state, the output slot is free this cycle.
  assign load = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  assign clr_busy = (state_r == ST_CLEAR);

  // Next state, store access and result words.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    emit_cnt_nxt  = emit_cnt_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    color_nxt     = color_r;
    page_nxt      = page_r;
    x_nxt         = x_r;
    after_nxt     = after_r;
    out_nxt       = out_r;
    out_valid_nxt = out_if.ready ? 1'b0 : out_valid_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = new_byte;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(FRAME_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          pop          = 1'b1;
          addr_nxt     = head_item.index[AW-1:0];
          bit_nxt      = head_item.bit_sel;
          color_nxt    = head_item.color;
          page_nxt     = head_item.page;
          x_nxt        = head_item.x;
          emit_cnt_nxt = '0;
          if (head_item.offscreen) begin
            kind_nxt  = STAT_OFFSCREEN;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        after_nxt = new_byte;
        if (new_byte != ram_rdata) begin
          ram_we   = 1'b1;
          kind_nxt = STAT_SENT;
        end else begin
          kind_nxt = STAT_UNCHANGED;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = kind_r;
          out_nxt.has_byte = (kind_r == STAT_SENT);
          out_nxt.is_data  = 1'b0;
          out_nxt.last     = 1'b0;
          out_nxt.out_byte = '0;
          if (kind_r != STAT_SENT) begin
            out_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            case (emit_cnt_r)
              2'd0:    out_nxt.out_byte = CMD_PAGE | {4'b0, page_r};
              2'd1:    out_nxt.out_byte = {4'b0, x_r[3:0]};
              2'd2:    out_nxt.out_byte = CMD_COL_HI | {4'b0, x_r[7:4]};
              default: begin
                out_nxt.out_byte = after_r;
                out_nxt.is_data  = 1'b1;
                out_nxt.last     = 1'b1;
              end
            endcase
            emit_cnt_nxt = emit_cnt_r + 1'b1;
            if (emit_cnt_r == 2'd3) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    bit_r   <= bit_nxt;
    color_r <= color_nxt;
    page_r  <= page_nxt;
    x_r     <= x_nxt;
    after_r <= after_nxt;
    out_r   <= out_nxt;
  end

  // Drive the result channel from the output register.
  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_r.out_byte;
  assign out_if.is_data  = out_r.is_data;
  assign out_if.has_byte = out_r.has_byte;
  assign out_if.last     = out_r.last;
  assign out_if.status   = out_r.status;

  `SOPW_ASSERT_NOW(a_no_pop_in_clear, state_r == ST_CLEAR, !pop, "pop during clear pass")
  `SOPW_ASSERT_NOW(a_write_only_on_change, ram_we && state_r == ST_LOOK, ram_wdata != ram_rdata, "store written with unchanged byte")
  `SOPW_ASSERT_NXT(a_last_ends_item, load && out_nxt.last, state_r == ST_IDLE, "item not finished after last word")
  `SOPW_ASSERT_NOW(a_byte_means_sent, out_valid_r && out_r.has_byte, out_r.status == STAT_SENT, "byte word without sent status")

endmodule

`default_nettype wire

### bench/shadowed_oled_pixel_writer_unit_test.sv
`timescale 1ns / 1ps

module shadowed_oled_pixel_writer_unit_test;
  import sopw_pkg::*;

  localparam int FRAME_BYTES = 1024;
  localparam int ROW_BYTES   = 128;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;

  // Track the panel's shadow frame and the words each accepted pixel owes.
  class frame_scoreboard;
    logic [7:0]   frame_bytes [FRAME_BYTES];
    sopw_result_t panel_words [$];
    int           errors;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      errors = 0;
    endfunction

    function sopw_result_t make_word(logic [7:0] b, logic d, logic h, logic l,
                                     sopw_status_t s);
      sopw_result_t w;
      w.out_byte = b;
      w.is_data  = d;
      w.has_byte = h;
      w.last     = l;
      w.status   = s;
      return w;
    endfunction

    // Apply one pixel write to the shadow copy and queue the words it causes.
    function void note_pixel(logic [7:0] px, logic [6:0] py, logic pc);
      logic [3:0]  page;
      int unsigned index;
      logic [7:0]  mask;
      logic [7:0]  old_byte;
      logic [7:0]  new_byte;
      page  = py[6:3];
      index = page * ROW_BYTES + px;
      if (index > FRAME_BYTES - 1) begin
        panel_words.push_back(make_word(8'h00, 1'b0, 1'b0, 1'b1, STAT_OFFSCREEN));
        return;
      end
      mask     = 8'h01 << py[2:0];
      old_byte = frame_bytes[index];
      new_byte = old_byte & ~mask;
      if (pc) new_byte = new_byte | mask;
      if (new_byte == old_byte) begin
        panel_words.push_back(make_word(8'h00, 1'b0, 1'b0, 1'b1, STAT_UNCHANGED));
        return;
      end
      frame_bytes[index] = new_byte;
      panel_words.push_back(make_word(CMD_PAGE | {4'h0, page}, 1'b0, 1'b1, 1'b0,
                                      STAT_SENT));
      panel_words.push_back(make_word({4'h0, px[3:0]}, 1'b0, 1'b1, 1'b0, STAT_SENT));
      panel_words.push_back(make_word(CMD_COL_HI | {4'h0, px[7:4]}, 1'b0, 1'b1, 1'b0,
                                      STAT_SENT));
      panel_words.push_back(make_word(new_byte, 1'b1, 1'b1, 1'b1, STAT_SENT));
    endfunction

    // Compare one accepted word with the oldest one owed.
    function void check_word(sopw_result_t got);
      sopw_result_t want;
      if (panel_words.size() == 0) begin
        $error("word with no pixel pending: out_byte %02h status %0d",
               got.out_byte, got.status);
        errors++;
        return;
      end
      want = panel_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_data !== want.is_data) begin
        $error("is_data: expected %0b, got %0b", want.is_data, got.is_data);
        errors++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return panel_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   recv_stall_pct;
  int   hold_asks;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;

  frame_scoreboard sb;
  sopw_result_t    got_word;

  sopw_in_if  pix_in ();
  sopw_out_if pix_out ();

  shadowed_oled_pixel_writer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_in),
    .out_if (pix_out)
  );

  // Free-running clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check accepted words, then pick the next ready; a requested hold-off
  // drops ready for a long stretch.
  always @(posedge clk) begin
    if (rst_n && pix_out.valid && pix_out.ready) begin
      got_word.out_byte = pix_out.out_byte;
      got_word.is_data  = pix_out.is_data;
      got_word.has_byte = pix_out.has_byte;
      got_word.last     = pix_out.last;
      got_word.status   = pix_out.status;
      sb.check_word(got_word);
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      pix_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("shadowed_oled_pixel_writer_unit_test: FAIL");
        $finish;
      end
    end
  end

  // Offer one pixel write, idling first at random, and hold it until taken.
  task automatic send_pixel(input logic [7:0] px, input logic [6:0] py,
                            input logic pc);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.x     <= px;
    pix_in.y     <= py;
    pix_in.color <= pc;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_pixel(px, py, pc);
  endtask

  // Most often a small corner that gets revisited, some whole-panel writes,
  // and a share across every field value, off screen included.
  task automatic send_random_pixel();
    int         pick;
    logic [7:0] px;
    logic [6:0] py;
    pick = $urandom_range(99);
    if (pick < 40) begin
      px = 8'($urandom_range(7));
      py = 7'($urandom_range(15));
    end else if (pick < 75) begin
      px = 8'($urandom_range(127));
      py = 7'($urandom_range(63));
    end else begin
      px = 8'($urandom_range(255));
      py = 7'($urandom_range(127));
    end
    send_pixel(px, py, 1'($urandom_range(1)));
  endtask

  // Hold the sender until every owed word has arrived.
  task automatic wait_drain();
    pix_in.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) send_random_pixel();
    wait_drain();
  endtask

  initial begin
    sb = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_asks       = 0;
    hold_seen       = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    pix_in.valid    = 1'b0;
    pix_in.x        = 8'h00;
    pix_in.y        = 7'h00;
    pix_in.color    = 1'b0;
    pix_out.ready   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: set, repeat, clear, edges of the panel, spill and off screen.
    send_pixel(8'd0,   7'd0,   1'b1);
    send_pixel(8'd0,   7'd0,   1'b1);
    send_pixel(8'd0,   7'd0,   1'b0);
    send_pixel(8'd0,   7'd0,   1'b0);
    send_pixel(8'd127, 7'd63,  1'b1);
    send_pixel(8'd255, 7'd0,   1'b1);
    send_pixel(8'd255, 7'd55,  1'b1);
    send_pixel(8'd255, 7'd56,  1'b1);
    send_pixel(8'd128, 7'd56,  1'b1);
    send_pixel(8'd127, 7'd56,  1'b1);
    send_pixel(8'd0,   7'd127, 1'b1);
    send_pixel(8'd255, 7'd127, 1'b0);
    send_pixel(8'h5A,  7'h2D,  1'b1);
    send_pixel(8'hA5,  7'h12,  1'b1);
    send_pixel(8'h5A,  7'h2D,  1'b0);
    send_pixel(8'd127, 7'd63,  1'b0);
    send_pixel(8'd127, 7'd63,  1'b1);
    send_pixel(8'd127, 7'd57,  1'b1);
    wait_drain();

    // Random phases with different idling on each side.
    run_random(46, 0, 0);
    run_random(44, 69, 0);
    run_random(44, 0, 69);
    run_random(44, 28, 28);

    // Back-pressure: stall the receiver while the sender keeps offering.
    sender_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_asks <= hold_asks + 1;
    repeat (14) send_random_pixel();
    wait_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d words never arrived", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("shadowed_oled_pixel_writer_unit_test: PASS");
    end else begin
      $display("shadowed_oled_pixel_writer_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sopw_pkg.sv
rtl/sopw_in_if.sv
rtl/sopw_out_if.sv
rtl/sopw_ram.sv
rtl/sopw_queue.sv
rtl/sopw_front.sv
rtl/sopw_back.sv
rtl/shadowed_oled_pixel_writer_unit.sv
bench/shadowed_oled_pixel_writer_unit_test.sv
